>>> src/sps_pkg.sv
// Package for the stepper phase sequencer: word types, command codes, constants,
// and the coil phase tables. It depends on nothing else.
package sps_pkg;

  // Register widths and limits.
  localparam int SPR_W = 14;
  localparam int DELAY_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam logic [SPR_W-1:0] MAX_STEPS_PER_REV = 14'd8192;
  localparam logic [SPR_W-1:0] SPR_RESET = 14'd2048;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd3500;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEPS_PER_REV = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_DELAY = 2'd2;

  // Move conversion: steps = |angle| * spr / 36000. The product is at most 2^36.
  // As 36000 = 32 * 1125, the product drops its five low bits (at most 2^31 is
  // left) and is then multiplied by ceil(2^41 / 1125) and shifted down by 41.
  // The rounding error of the reciprocal is 823/2^41 per unit, which keeps the
  // quotient exact up to 2^31; the quotient stays below 2^21.
  localparam int ANGLE_W = 24;
  localparam int MAG_W = 24;
  localparam int PROD_W = 37;
  localparam int PRE_SHIFT = 5;
  localparam int PRE_W = PROD_W - PRE_SHIFT;
  localparam int RECIP_W = 31;
  localparam logic [RECIP_W-1:0] STEP_RECIP = 31'd1954687339;
  localparam int RECIP_SHIFT = 41;
  localparam int RPROD_W = PRE_W + RECIP_W;
  localparam int QUOT_W = 21;
  localparam int STEPS_W = 22;

  // Sweep span = floor(spr * 11 / 36), by reciprocal: exact for spr*11 < 209715.
  localparam int SPAN_W = 12;
  localparam int SPAN_Y_W = 17;
  localparam logic [SPAN_Y_W-1:0] SPAN_RECIP = 17'd116509;
  localparam int SPAN_SHIFT = 22;

  localparam int HOLD_W = 16;
  localparam int PHASE_W = 3;
  localparam int TRIGGER_TICKS = 500;
  localparam int PULSE_W = $clog2(TRIGGER_TICKS + 1);

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_MOVE     = 3'd1,
    OP_ROT_CW   = 3'd2,
    OP_ROT_CCW  = 3'd3,
    OP_SWEEP    = 3'd4,
    OP_TRIGGER  = 3'd5,
    OP_LASER    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_MOVE,
    CMD_ROTATE,
    CMD_SWEEP,
    CMD_TRIGGER,
    CMD_LASER,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    MOTION_IDLE   = 2'd0,
    MOTION_MOVE   = 2'd1,
    MOTION_ROTATE = 2'd2,
    MOTION_SWEEP  = 2'd3
  } motion_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [ANGLE_W-1:0] angle;
    logic                      laser_on;
  } in_word_t;

  typedef struct packed {
    logic [3:0] coil_drive;
    logic       laser_out;
    logic       trigger_out;
    logic       busy_res;
    logic       ack;
  } res_word_t;

  // A classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_kind_t          kind;
    logic               rev;
    logic               laser_on;
    logic [QUOT_W-1:0]  steps;
  } cmd_t;

  localparam logic [3:0] FULL_TAB [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
  localparam logic [3:0] HALF_TAB [8] = '{4'd1, 4'd3, 4'd2, 4'd6,
                                          4'd4, 4'd12, 4'd8, 4'd9};

  function automatic logic [3:0] coil_lookup(input logic half, input logic [PHASE_W-1:0] idx);
    logic [3:0] c;
    c = half ? HALF_TAB[idx] : FULL_TAB[idx[1:0]];
    return c;
  endfunction

  function automatic logic [SPR_W-1:0] spr_limit(input logic [SPR_W-1:0] s);
    logic [SPR_W-1:0] r;
    r = (s > MAX_STEPS_PER_REV) ? MAX_STEPS_PER_REV : s;
    return r;
  endfunction

endpackage

>>> src/sps_front.sv
// Front end of the stepper phase sequencer: accepts input words, classifies them,
// and converts move angles to step counts. Depends on sps_pkg.
module sps_front import sps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_word_t         item,
  input  logic [SPR_W-1:0] steps_per_rev,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_data
);

  front_state_t state;
  front_state_t state_next;

  logic [MAG_W-1:0]     mag;
  logic [SPR_W-1:0]     spr;
  logic                 neg;
  logic [PRE_W-1:0]     pre;
  logic [QUOT_W-1:0]    quot;

  logic [PROD_W-1:0]    prod;
  logic [RPROD_W-1:0]   rprod;
  cmd_t                 cls;
  logic                 is_move;
  logic                 accept;

  // Classification of the incoming word.
  always_comb begin
    cls = '{kind: CMD_NOP, rev: 1'b0, laser_on: item.laser_on, steps: '0};
    is_move = 1'b0;
    unique case (op_t'(item.op))
      OP_TICK:    cls.kind = CMD_TICK;
      OP_MOVE:    is_move = 1'b1;
      OP_ROT_CW:  cls.kind = CMD_ROTATE;
      OP_ROT_CCW: begin
        cls.kind = CMD_ROTATE;
        cls.rev = 1'b1;
      end
      OP_SWEEP:   cls.kind = CMD_SWEEP;
      OP_TRIGGER: cls.kind = CMD_TRIGGER;
      OP_LASER:   cls.kind = CMD_LASER;
      default:    cls.kind = CMD_NOP;
    endcase
  end

  assign accept = push && !full;
  assign prod = PROD_W'(mag) * PROD_W'(spr);
  // Division by 1125 of the product without its five low bits, by reciprocal.
  assign rprod = RPROD_W'(pre) * RPROD_W'(STEP_RECIP);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept && is_move) state_next = FR_MUL;
      end
      FR_MUL:  state_next = FR_DIV;
      FR_DIV:  state_next = FR_PUSH;
      FR_PUSH: begin
        if (!q_full) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    full = 1'b1;
    q_push = 1'b0;
    q_data = cls;
    unique case (state)
      FR_IDLE: begin
        full = q_full;
        q_push = push && !q_full && !is_move;
      end
      FR_PUSH: begin
        q_push = !q_full;
        q_data = '{kind: CMD_MOVE, rev: neg, laser_on: 1'b0, steps: quot};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the angle, multiply by steps per revolution, then divide by 36000.
  always_ff @(posedge clk) begin
    unique case (state)
      FR_IDLE: begin
        neg <= item.angle[ANGLE_W-1];
        mag <= item.angle[ANGLE_W-1] ? MAG_W'(-item.angle) : MAG_W'(item.angle);
        spr <= spr_limit(steps_per_rev);
      end
      FR_MUL:  pre <= prod[PROD_W-1:PRE_SHIFT];
      FR_DIV:  quot <= rprod[RECIP_SHIFT +: QUOT_W];
      default: ;
    endcase
  end

endmodule

>>> src/sps_cmdq.sv
// Two-entry command queue between the front and back of the stepper phase
// sequencer. Depends on sps_pkg.
module sps_cmdq import sps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_push,
  input  cmd_t q_data,
  output logic q_full,
  input  logic q_pop,
  output logic q_empty,
  output cmd_t q_head
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_full = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign q_head = mem[rd_ptr];
  assign do_push = q_push && !q_full;
  assign do_pop = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= q_data;
  end

endmodule

>>> src/sps_back.sv
// Back end of the stepper phase sequencer: motion state, phase tables, trigger
// and laser, and a two-entry result queue. Depends on sps_pkg.
module sps_back import sps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               half_step_mode,
  input  logic [SPR_W-1:0]   steps_per_rev,
  input  logic [DELAY_W-1:0] phase_delay,
  input  logic               cmd_empty,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output res_word_t          result
);

  motion_t             mode;
  logic                rev;
  logic [PHASE_W-1:0]  phase;
  logic [STEPS_W-1:0]  steps_left;
  logic [SPAN_W-1:0]   passes;
  logic [HOLD_W-1:0]   hold;
  logic [3:0]          coil;
  logic                laser;
  logic [PULSE_W-1:0]  pulse;
  logic [SPAN_W-1:0]   span;

  motion_t             mode_next;
  logic                rev_next;
  logic [PHASE_W-1:0]  phase_next;
  logic [STEPS_W-1:0]  steps_next;
  logic [SPAN_W-1:0]   passes_next;
  logic [HOLD_W-1:0]   hold_next;
  logic [3:0]          coil_next;
  logic                laser_next;
  logic [PULSE_W-1:0]  pulse_next;
  logic                ack;

  logic [PHASE_W-1:0]  mask;
  logic [PHASE_W-1:0]  p;
  logic [PHASE_W-1:0]  load_idx;
  logic                load;
  logic [STEPS_W-1:0]  steps_dec;
  logic [SPAN_W-1:0]   passes_inc;
  logic [SPAN_Y_W-1:0] span_y;
  logic [SPAN_Y_W+SPAN_Y_W-1:0] span_prod;

  res_word_t           res_mem [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                fire;
  logic                do_pop;

  // Sweep span follows cfg; user changes it only while block idle; unenforced.
  assign span_y = (SPAN_Y_W'(spr_limit(steps_per_rev)) << 3)
                + (SPAN_Y_W'(spr_limit(steps_per_rev)) << 1)
                + SPAN_Y_W'(spr_limit(steps_per_rev));
  assign span_prod = (SPAN_Y_W+SPAN_Y_W)'(span_y) * (SPAN_Y_W+SPAN_Y_W)'(SPAN_RECIP);

  always_ff @(posedge clk) begin
    span <= span_prod[SPAN_SHIFT +: SPAN_W];
  end

  assign mask = half_step_mode ? 3'd7 : 3'd3;
  assign p = phase & mask;
  assign steps_dec = (steps_left != '0) ? steps_left - STEPS_W'(1) : steps_left;
  assign passes_inc = passes + SPAN_W'(1);

  always_comb begin
    mode_next = mode;
    rev_next = rev;
    phase_next = phase;
    steps_next = steps_left;
    passes_next = passes;
    hold_next = hold;
    coil_next = coil;
    laser_next = laser;
    pulse_next = pulse;
    ack = 1'b1;
    load = 1'b0;
    load_idx = '0;
    case (cmd.kind)
      CMD_TICK: begin
        ack = 1'b0;
        if (pulse != '0) pulse_next = pulse - PULSE_W'(1);
        if (mode != MOTION_IDLE) begin
          if (hold > HOLD_W'(1)) begin
            hold_next = hold - HOLD_W'(1);
          end else begin
            hold_next = '0;
            load_idx = (p + PHASE_W'(1)) & mask;
            if (mode == MOTION_MOVE) begin
              steps_next = steps_dec;
              if (steps_dec == '0) mode_next = MOTION_IDLE;
              else load = 1'b1;
            end else begin
              load = 1'b1;
              if (mode == MOTION_SWEEP && p == mask) begin
                if (passes_inc >= span) begin
                  rev_next = !rev;
                  passes_next = '0;
                end else begin
                  passes_next = passes_inc;
                end
              end
            end
          end
        end
      end
      CMD_MOVE: begin
        if (cmd.steps == '0) begin
          mode_next = MOTION_IDLE;
          coil_next = 4'd0;
          steps_next = '0;
          hold_next = '0;
        end else begin
          mode_next = MOTION_MOVE;
          rev_next = cmd.rev;
          passes_next = '0;
          steps_next = STEPS_W'(cmd.steps);
          load = 1'b1;
        end
      end
      CMD_ROTATE: begin
        mode_next = MOTION_ROTATE;
        rev_next = cmd.rev;
        passes_next = '0;
        steps_next = '0;
        load = 1'b1;
      end
      CMD_SWEEP: begin
        mode_next = MOTION_SWEEP;
        rev_next = 1'b1;
        passes_next = '0;
        steps_next = '0;
        load = 1'b1;
      end
      CMD_TRIGGER: pulse_next = PULSE_W'(TRIGGER_TICKS);
      CMD_LASER:   laser_next = cmd.laser_on;
      default:     ack = 1'b0;
    endcase
    if (load) begin
      phase_next = load_idx;
      coil_next = coil_lookup(half_step_mode, rev_next ? (mask - load_idx) : load_idx);
      hold_next = phase_delay;
    end
  end

  assign do_pop = pop && !empty;
  assign fire = !cmd_empty && (count != 2'd2 || do_pop);
  assign cmd_pop = fire;
  assign empty = count == 2'd0;
  assign result = res_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MOTION_IDLE;
      rev <= 1'b0;
      phase <= '0;
      steps_left <= '0;
      passes <= '0;
      hold <= '0;
      coil <= 4'd0;
      laser <= 1'b0;
      pulse <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (fire) begin
        mode <= mode_next;
        rev <= rev_next;
        phase <= phase_next;
        steps_left <= steps_next;
        passes <= passes_next;
        hold <= hold_next;
        coil <= coil_next;
        laser <= laser_next;
        pulse <= pulse_next;
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) rd_ptr <= !rd_ptr;
      if (fire && !do_pop) count <= count + 2'd1;
      else if (do_pop && !fire) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_mem[wr_ptr] <= '{coil_drive: coil_next, laser_out: laser_next,
                           trigger_out: pulse_next != '0,
                           busy_res: mode_next != MOTION_IDLE, ack: ack};
    end
  end

endmodule

>>> src/stepper_phase_sequencer.sv
// Top level of the stepper phase sequencer: configuration registers and the
// front, command queue and back. Depends on sps_pkg, sps_front, sps_cmdq, sps_back.
//
// This block sequences the four coils of a unipolar stepper motor. Every input word
// gives exactly one result word, in order. A tick word stands for one microsecond;
// each phase of the full-step (four-phase) or half-step (eight-phase) table is held
// for phase_delay ticks. Command words start a move by an angle in hundredths of a
// degree, continuous rotation, or a sweep, or they fire the trigger pulse (high for
// 500 ticks including the command word) or set the laser. Tick and all non-move words
// are taken at one per clock, also while earlier results wait to be popped, until the
// two-word result queue and the two-entry command queue are both full. A move word
// passes through the front states in order: it is latched, the angle is multiplied
// by steps-per-revolution, the product is divided by 36000 as a reciprocal multiply,
// and the step count is handed on, which waits while the command queue is full; the
// input reports full after the latch until the count is handed on. Each result passes
// through the command queue and then the result queue. The user must write registers
// through the cfg port only while the block is idle; the block does not enforce this.

module stepper_phase_sequencer import sps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  in_word_t               item,
  output logic                   empty,
  input  logic                   pop,
  output res_word_t              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic               half_step_mode;
  logic [SPR_W-1:0]   steps_per_rev;
  logic [DELAY_W-1:0] phase_delay;

  logic q_push;
  cmd_t q_data;
  logic q_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_head;

  // Configuration registers; a write to an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode <= 1'b0;
      steps_per_rev <= SPR_RESET;
      phase_delay <= DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_STEP:     half_step_mode <= cfg_data[0];
        CFG_STEPS_PER_REV: steps_per_rev <= cfg_data[SPR_W-1:0];
        CFG_PHASE_DELAY:   phase_delay <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // The front classifies words and converts move angles to step counts.
  sps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .steps_per_rev (steps_per_rev),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  // A short queue lets the front keep going while the result side stalls.
  sps_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full),
    .q_pop   (cmd_pop),
    .q_empty (cmd_empty),
    .q_head  (cmd_head)
  );

  // The back carries out one command per cycle while its result queue has room.
  sps_back u_back (
    .clk            (clk),
    .rst            (rst),
    .half_step_mode (half_step_mode),
    .steps_per_rev  (steps_per_rev),
    .phase_delay    (phase_delay),
    .cmd_empty      (cmd_empty),
    .cmd            (cmd_head),
    .cmd_pop        (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .result         (result)
  );

  // A move word keeps the front busy for its conversion, so the next cycle is full.
  a_move_blocks: assert property (@(posedge clk) disable iff (rst)
    push && !full && item.op == OP_MOVE |=> full)
    else $error("move accepted but front did not block the input");

  // The back never takes a command from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("back popped an empty command queue");

  // The front never offers a command while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("front pushed into a full command queue");

  // A converted step count never exceeds the quotient range of the divider.
  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    q_push && q_data.kind == CMD_MOVE |-> q_data.steps <= QUOT_W'(1908874))
    else $error("move step count out of range");

endmodule

>>> dv/stepper_phase_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for stepper_phase_sequencer: a scoreboard class that predicts
// every result word, and plain tasks that drive the queue-style ports. Depends on sps_pkg.

class stepper_scoreboard;
  // Coil tables packed four bits per phase, phase 0 in the lowest nibble.
  localparam logic [15:0] FULL_COILS = 16'h8421;
  localparam logic [31:0] HALF_COILS = 32'h98C46231;
  localparam logic [21:0] STEP_LIMIT = 22'h3FFFFF;

  // Register copies.
  bit        half_step;
  bit [13:0] spr;
  bit [15:0] phase_delay;

  // Motion and output state.
  sps_pkg::motion_t motion;
  bit          rev;
  bit [2:0]    phase_idx;
  bit [21:0]   steps_left;
  bit [11:0]   sweep_passes;
  bit [15:0]   hold;
  bit [3:0]    coils;
  bit          laser;
  int unsigned pulse;

  sps_pkg::res_word_t expected_q[$];
  int mismatches;

  function new();
    half_step = 1'b0;
    spr = sps_pkg::SPR_RESET;
    phase_delay = sps_pkg::DELAY_RESET;
    motion = sps_pkg::MOTION_IDLE;
    rev = 1'b0;
    phase_idx = '0;
    steps_left = '0;
    sweep_passes = '0;
    hold = '0;
    coils = '0;
    laser = 1'b0;
    pulse = 0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [sps_pkg::CFG_INDEX_W-1:0] idx,
                          logic [sps_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      sps_pkg::CFG_HALF_STEP:     half_step = val[0];
      sps_pkg::CFG_STEPS_PER_REV: spr = val[13:0];
      sps_pkg::CFG_PHASE_DELAY:   phase_delay = val;
      default: ;
    endcase
  endfunction

  function int unsigned table_len();
    return half_step ? 8 : 4;
  endfunction

  function int unsigned spr_limited();
    return (spr > sps_pkg::MAX_STEPS_PER_REV) ? sps_pkg::MAX_STEPS_PER_REV : spr;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Put the current phase on the coils and restart its hold time.
  function void show_phase();
    int unsigned len, p, i;
    len = table_len();
    p = phase_idx & (len - 1);
    i = rev ? (len - 1 - p) : p;
    coils = half_step ? HALF_COILS[i*4 +: 4] : FULL_COILS[i*4 +: 4];
    hold = phase_delay;
  endfunction

  function void start(sps_pkg::motion_t m, bit r);
    motion = m;
    rev = r;
    phase_idx = '0;
    sweep_passes = '0;
    show_phase();
  endfunction

  function void tick_motion();
    int unsigned len, p, span;
    if (motion == sps_pkg::MOTION_IDLE) return;
    if (hold > 1) begin
      hold--;
      return;
    end
    hold = '0;
    len = table_len();
    p = phase_idx & (len - 1);
    if (motion == sps_pkg::MOTION_MOVE) begin
      if (steps_left > 0) steps_left--;
      if (steps_left == 0) begin
        // The last phase stays on the coils.
        motion = sps_pkg::MOTION_IDLE;
        return;
      end
    end else if (motion == sps_pkg::MOTION_SWEEP && p == len - 1) begin
      span = spr_limited() * 110 / 360;
      sweep_passes = sweep_passes + 12'd1;
      if (sweep_passes >= span) begin
        rev = ~rev;
        sweep_passes = '0;
      end
    end
    phase_idx = 3'((p + 1) & (len - 1));
    show_phase();
  endfunction

  function void note_input(sps_pkg::in_word_t w);
    longint a;
    longint unsigned mag, steps;
    bit ack;
    sps_pkg::res_word_t r;
    ack = 1'b0;
    case (w.op)
      sps_pkg::OP_TICK: begin
        tick_motion();
        if (pulse > 0) pulse--;
      end
      sps_pkg::OP_MOVE: begin
        a = longint'($signed(w.angle));
        mag = (a < 0) ? -a : a;
        steps = mag * spr_limited() / 36000;
        ack = 1'b1;
        if (steps == 0) begin
          motion = sps_pkg::MOTION_IDLE;
          coils = '0;
          steps_left = '0;
          hold = '0;
        end else begin
          if (steps > STEP_LIMIT) steps = STEP_LIMIT;
          start(sps_pkg::MOTION_MOVE, a < 0);
          steps_left = steps[21:0];
        end
      end
      sps_pkg::OP_ROT_CW, sps_pkg::OP_ROT_CCW: begin
        ack = 1'b1;
        steps_left = '0;
        start(sps_pkg::MOTION_ROTATE, w.op == sps_pkg::OP_ROT_CCW);
      end
      sps_pkg::OP_SWEEP: begin
        ack = 1'b1;
        steps_left = '0;
        start(sps_pkg::MOTION_SWEEP, 1'b1);
      end
      sps_pkg::OP_TRIGGER: begin
        ack = 1'b1;
        pulse = sps_pkg::TRIGGER_TICKS;
      end
      sps_pkg::OP_LASER: begin
        ack = 1'b1;
        laser = w.laser_on;
      end
      default: ;
    endcase
    r.coil_drive = coils;
    r.laser_out = laser;
    r.trigger_out = (pulse != 0);
    r.busy_res = (motion != sps_pkg::MOTION_IDLE);
    r.ack = ack;
    expected_q = {expected_q, r};
  endfunction

  function void check_result(sps_pkg::res_word_t got);
    sps_pkg::res_word_t exp;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    exp = expected_q.pop_front();
    if (got.coil_drive !== exp.coil_drive || got.laser_out !== exp.laser_out ||
        got.trigger_out !== exp.trigger_out || got.busy_res !== exp.busy_res ||
        got.ack !== exp.ack) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: coils %h/%h laser %b/%b trig %b/%b busy %b/%b ack %b/%b",
                 $realtime, exp.coil_drive, got.coil_drive, exp.laser_out, got.laser_out,
                 exp.trigger_out, got.trigger_out, exp.busy_res, got.busy_res,
                 exp.ack, got.ack);
    end
  endfunction
endclass

module stepper_phase_sequencer_test;
  import sps_pkg::*;

  // The one op code that the package leaves unnamed; the block must ignore it.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 137;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  in_word_t               item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  res_word_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  stepper_scoreboard sb = new();

  int stall_cycles = 0;
  bit hold_off_req = 1'b0;
  int send_calm = 0;
  int recv_calm = 0;

  stepper_phase_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog counts cycles in which no word moves on either side and no register
  // is written. A correct run never sits still for anything like this long.
  always @(posedge clk) begin
    if (rst || cfg_we || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Gap lengths for both sides: mostly none or short, a few long, and now and then a
  // calm stretch with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t make_word(logic [2:0] op, logic [ANGLE_W-1:0] angle,
                                         logic laser_on);
    in_word_t w;
    w.op = op;
    w.angle = angle;
    w.laser_on = laser_on;
    return w;
  endfunction

  // Move angles are mostly chosen to give a handful of steps at the current
  // steps-per-revolution, so that moves run to their end; some are near zero and
  // some take any value at all.
  function automatic logic [ANGLE_W-1:0] move_angle();
    int unsigned s, mag, sel;
    s = sb.spr_limited();
    if (s == 0) s = 1;
    sel = $urandom_range(0, 9);
    if (sel < 2) return ANGLE_W'($urandom);
    if (sel == 2) mag = $urandom_range(0, 3);
    else mag = $urandom_range(0, 36000 * 6 / s + 1);
    return $urandom_range(0, 1) ? ANGLE_W'(-int'(mag)) : ANGLE_W'(mag);
  endfunction

  function automatic in_word_t rand_command();
    logic [2:0] op;
    op = 3'($urandom_range(1, 7));
    if (op == OP_MOVE) return make_word(op, move_angle(), 1'($urandom_range(0, 1)));
    return make_word(op, ANGLE_W'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  function automatic in_word_t rand_tick();
    return make_word(OP_TICK, ANGLE_W'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  // Offer one word after a random gap and hold it until the block takes it. Push is
  // only lowered when a gap is wanted, so back-to-back words keep it high.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    sb.note_input(w);
  endtask

  // Stop offering, let every predicted word come back, and then give the block a
  // little longer so that nothing is still in flight before a register changes.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(input logic half, input logic [CFG_DATA_W-1:0] spr,
                          input logic [CFG_DATA_W-1:0] delay);
    drain();
    write_reg(CFG_HALF_STEP, {15'd0, half});
    write_reg(CFG_STEPS_PER_REV, spr);
    write_reg(CFG_PHASE_DELAY, delay);
  endtask

  // Random words come as a command followed by a run of ticks, which is what lets
  // moves finish, sweeps turn back and the trigger pulse run out. Half way through,
  // the receiver may be asked to hold off so that the block backs up.
  task automatic run_random(input int n_words, input bit ask_hold);
    int sent, run, r;
    bit asked;
    sent = 0;
    asked = 1'b0;
    while (sent < n_words) begin
      send_word(rand_command());
      sent++;
      r = $urandom_range(0, 9);
      if (r < 2) run = $urandom_range(0, 2);
      else if (r < 9) run = $urandom_range(1, 30);
      else run = $urandom_range(40, 120);
      repeat (run) begin
        send_word(rand_tick());
        sent++;
        if (ask_hold && !asked && sent >= n_words / 2) begin
          hold_off_req = 1'b1;
          asked = 1'b1;
        end
      end
    end
  endtask

  // Receiver: pops with random gaps, and once asked, stops popping for a long
  // stretch while the sender keeps offering words.
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = pick_gap(recv_calm);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(result);
    end
  end

  initial begin
    logic        half_list [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                               1'b1, 1'b0, 1'b1, 1'b0};
    int unsigned spr_list [RANDOM_PHASES] = '{8192, 3, 5, 16383, 1, 2048, 10, 7};
    int unsigned delay_list [RANDOM_PHASES] = '{2, 1, 3, 0, 1, 65535, 2, 4};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: idle levels, the unused op, laser, trigger and a zero-step move.
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_UNUSED, 24'h7FFFFF, 1'b1));
    send_word(make_word(OP_LASER, '0, 1'b1));
    send_word(make_word(OP_TRIGGER, '0, 1'b0));
    send_word(make_word(OP_MOVE, '0, 1'b0));
    send_word(make_word(OP_TICK, 24'hFFFFFF, 1'b1));

    // Full steps, one tick per phase: a one-step move each way runs to its end,
    // then rotation both ways, a sweep, a trigger restart and the angle extremes.
    set_mode(1'b0, 16'd8192, 16'd1);
    send_word(make_word(OP_MOVE, 24'd5, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_MOVE, -24'sd5, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_ROT_CW, '0, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_ROT_CCW, '0, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_SWEEP, '0, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_TRIGGER, '0, 1'b0));
    send_word(make_word(OP_TRIGGER, '0, 1'b0));
    send_word(make_word(OP_MOVE, 24'h7FFFFF, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    send_word(make_word(OP_MOVE, 24'h800000, 1'b0));
    send_word(make_word(OP_TICK, '0, 1'b0));
    // A tiny negative angle gives no steps, so the coils go off.
    send_word(make_word(OP_MOVE, 24'hFFFFFF, 1'b1));
    send_word(make_word(OP_LASER, 24'hFFFFFF, 1'b0));

    // Random phases. Motion left running carries across each change of settings,
    // which also covers a change of table in the middle of a rotation or sweep.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_mode(half_list[ph], CFG_DATA_W'(spr_list[ph]), CFG_DATA_W'(delay_list[ph]));
      run_random(WORDS_PER_PHASE, ph == 1 || ph == 4);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
